// ===== hdl/pa_pkg.sv =====
// ----------------------------------------------------------------------------
// pa_pkg: shared types and constants for the positional array block
// Request codes, fixed field widths and the default capacity.
// ----------------------------------------------------------------------------
package pa_pkg;

    // fixed field widths
    localparam int POS_W  = 11;
    localparam int WORD_W = 32;

    // default number of stored words
    localparam int CAPACITY_DEF = 1024;

    // request kinds
    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_SET    = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_REMOVE = 2'd3
    } req_t;

endpackage

// ===== hdl/pa_ram.sv =====
// ----------------------------------------------------------------------------
// pa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/pa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pa_ctrl: request sequencer for the positional array
// Checks each request, walks one shared index stepper over the RAM to move
// words up or down one per cycle, and registers the result beat.
// ----------------------------------------------------------------------------
module pa_ctrl #(
    parameter int CAPACITY = pa_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request side
    input  logic                        start,
    input  logic [1:0]                  req_type,
    input  logic [pa_pkg::POS_W-1:0]    position,
    input  logic signed [pa_pkg::WORD_W-1:0] value,
    output logic                        busy,
    // result side
    output logic                        done,
    output logic                        ok,
    output logic signed [pa_pkg::WORD_W-1:0] read_value,
    output logic [pa_pkg::POS_W-1:0]    count,
    // RAM port
    output logic                        ram_we,
    output logic [$clog2(CAPACITY)-1:0] ram_waddr,
    output logic [pa_pkg::WORD_W-1:0]   ram_wdata,
    output logic                        ram_re,
    output logic [$clog2(CAPACITY)-1:0] ram_raddr,
    input  logic [pa_pkg::WORD_W-1:0]   ram_rdata
);

    import pa_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_RDATA,
        S_FIN
    } state_t;

    state_t                    state_reg, state_next;
    req_t                      req_reg, req_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [WORD_W-1:0]         value_reg, value_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [ADDR_W-1:0]         dst_reg, dst_next;
    logic                      pend_reg, pend_next;
    logic                      done_reg, done_next;
    logic                      ok_reg, ok_next;
    logic [WORD_W-1:0]         rdval_reg, rdval_next;
    logic [POS_W-1:0]          count_reg, count_next;

    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic [CMP_W-1:0]          idx_ext;
    logic [CNT_W-1:0]          idx_step;
    logic                      in_range;
    logic                      can_ins;
    logic                      more;

    // shared index stepper: down for insert, up for remove
    assign idx_step = (req_reg == REQ_INSERT) ? idx_reg - CNT_W'(1) : idx_reg + CNT_W'(1);

    // range checks
    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign idx_ext  = CMP_W'(idx_reg);
    assign in_range = pos_ext < cnt_ext;
    assign can_ins  = (cnt_reg != CNT_W'(CAPACITY)) && (pos_ext <= cnt_ext);
    assign more     = (req_reg == REQ_INSERT) ? (idx_ext > pos_ext)
                                              : (CMP_W'(idx_step) < cnt_ext);

    // next-state and RAM control
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        pos_next   = pos_reg;
        value_next = value_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        dst_next   = dst_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        rdval_next = rdval_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_waddr  = ADDR_W'(pos_ext);
        ram_wdata  = value_reg;
        ram_re     = 1'b0;
        ram_raddr  = ADDR_W'(pos_ext);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_t'(req_type);
                    pos_next   = position;
                    value_next = value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // default: rejected request, report at once
                state_next = S_IDLE;
                done_next  = 1'b1;
                ok_next    = 1'b0;
                rdval_next = '0;
                count_next = POS_W'(cnt_reg);
                case (req_reg)
                    REQ_READ:
                    begin
                        if (in_range)
                        begin
                            ram_re     = 1'b1;
                            done_next  = 1'b0;
                            state_next = S_RDATA;
                        end
                    end
                    REQ_SET:
                    begin
                        if (in_range)
                        begin
                            ram_we  = 1'b1;
                            ok_next = 1'b1;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (can_ins)
                        begin
                            idx_next   = cnt_reg;
                            done_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (in_range)
                        begin
                            idx_next   = CNT_W'(pos_ext);
                            done_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // retire the word fetched last cycle
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                // fetch the next word to move
                if (more)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_step[ADDR_W-1:0];
                    dst_next  = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_step;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_FIN;
                end
            end

            S_RDATA:
            begin
                done_next  = 1'b1;
                ok_next    = 1'b1;
                rdval_next = ram_rdata;
                count_next = POS_W'(cnt_reg);
                state_next = S_IDLE;
            end

            S_FIN:
            begin
                if (req_reg == REQ_INSERT)
                begin
                    ram_we   = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                done_next  = 1'b1;
                ok_next    = 1'b1;
                rdval_next = '0;
                count_next = POS_W'(cnt_next);
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        pos_reg   <= pos_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        dst_reg   <= dst_next;
        ok_reg    <= ok_next;
        rdval_reg <= rdval_next;
        count_reg <= count_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign read_value = rdval_reg;
    assign count      = count_reg;

endmodule

// ===== hdl/positional_array_insert_remove.sv =====
// ----------------------------------------------------------------------------
// positional_array_insert_remove: bounded positional list of signed words
// A read passes the check and RAM read states; a set or a rejected request is
// answered from the check; insert/remove shift words, then update the count.
// Words move through the single RAM write port one word per cycle. A new request
// is taken only in idle; busy stays high until the result.
// Reset clears the count and the control state; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module positional_array_insert_remove #(
    parameter int CAPACITY = pa_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       req_type,
    input  logic [pa_pkg::POS_W-1:0]         position,
    input  logic signed [pa_pkg::WORD_W-1:0] value,
    output logic                             done,
    output logic                             ok,
    output logic signed [pa_pkg::WORD_W-1:0] read_value,
    output logic [pa_pkg::POS_W-1:0]         count
);

    import pa_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // sequencer
    pa_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .position   (position),
        .value      (value),
        .busy       (busy),
        .done       (done),
        .ok         (ok),
        .read_value (read_value),
        .count      (count),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // element store
    pa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTH
    // a result beat is only shown once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // a rejected request never carries a read word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (read_value == '0))
        else $error("rejected request with nonzero read word");

    // an accepted beat makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start the sequencer");

    // no result beat right after an accept
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result beat too early");
`endif

endmodule
